// ===== rtl/core/mjsd_pkg.sv =====
`timescale 1ns / 1ps

package mjsd_pkg;

    // Parser mode
    typedef enum logic [2:0] {
        MODE_MAIN  = 3'b001,
        MODE_PART  = 3'b010,
        MODE_FRAME = 3'b100
    } mode_t;

    // Content-Length value scan phase
    typedef enum logic [2:0] {
        PH_BLANK = 3'b001,
        PH_DIGIT = 3'b010,
        PH_DONE  = 3'b100
    } phase_t;

    // Lead byte tracking at the start of a stream
    typedef enum logic [2:0] {
        LEAD_NONE = 3'b001,
        LEAD_ONE  = 3'b010,
        LEAD_DONE = 3'b100
    } lead_t;

    // One result transaction
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       frame_last;
    } result_t;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    // "Content-Length:" is 15 characters; the value scan begins at position 16
    localparam int unsigned TAG_LEN   = 15;
    localparam int unsigned VALUE_POS = 16;
    localparam logic [1:0]  BOUNDARY_LEN = 2'd2;

    typedef logic [7:0] tag_rom_t [TAG_LEN];

    localparam tag_rom_t LEN_TAG = '{
        8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
        8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A
    };

endpackage

// ===== rtl/core/multipart_jpeg_stream_deframer.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Transfer when        tdata            tuser          tlast
// s_*      in   s_tvalid & s_tready  [7:0] byte_value [0] stream_start stream_end
// m_*      out  m_tvalid & m_tready  [7:0] payload    [0] payload_valid frame_last
//
// One input transaction per cycle while s_tready is high; each is parsed in the cycle it is accepted.
// An input produces zero, one or two results, held in a 3-entry output queue;
// s_tready is high while the queue holds at most one result.
// Throughput is one byte per cycle while m_tready stays high, except that input
// stalls after a lead byte pair that releases two results.
// aresetn is synchronous, active low, and returns the parser to the main header.
module multipart_jpeg_stream_deframer #(
    parameter int LINE_CAP    = 1000,
    parameter int LENGTH_BITS = 24
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_value
    input  logic [0:0] s_tuser,   // [0] stream_start
    input  logic       s_tlast,   // stream_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] payload_byte
    output logic [0:0] m_tuser,   // [0] payload_valid
    output logic       m_tlast    // frame_last
);

    localparam int LL_W = $clog2(LINE_CAP + 1);
    localparam int QD   = 3;
    localparam logic [LL_W-1:0] LINE_CAP_W = LL_W'(LINE_CAP);
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    // Parser state
    mjsd_pkg::mode_t         mode_reg, mode_next, cur_mode;
    logic [LL_W-1:0]         line_reg, line_next, cur_line;
    logic [3:0]              tag_reg, tag_next, cur_tag;
    logic [1:0]              bnd_reg, bnd_next, cur_bnd;
    logic [7:0]              lastc_reg, lastc_next, cur_lastc;
    mjsd_pkg::phase_t        phase_reg, phase_next, cur_phase;
    logic [LENGTH_BITS-1:0]  accum_reg, accum_next, cur_accum;
    logic [LENGTH_BITS-1:0]  flen_reg, flen_next, cur_flen;
    logic [LENGTH_BITS-1:0]  off_reg, off_next, cur_off;
    logic                    seen_reg, seen_next, cur_seen;
    mjsd_pkg::lead_t         lead_reg, lead_next, cur_lead;
    logic [7:0]              held_reg, held_next, cur_held;
    logic                    single_reg, single_next, cur_single;

    // Output queue
    mjsd_pkg::result_t       q_reg [QD];
    mjsd_pkg::result_t       q_next [QD];
    logic [1:0]              cnt_reg, cnt_next, cnt_pop;

    logic                    accept, pop, restart;
    logic [7:0]              b;
    logic                    push0, push1;
    mjsd_pkg::result_t       res0, res1;
    logic                    set_seen;
    logic [LENGTH_BITS-1:0]  new_flen;
    logic                    is_digit, is_blank;
    logic [LENGTH_BITS+3:0]  accum_mul;
    logic [LENGTH_BITS-1:0]  accum_sat, off_inc;
    logic                    frame_done;

    assign accept   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign s_tready = (cnt_reg <= 2'd1);
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = q_reg[0].payload_byte;
    assign m_tuser  = q_reg[0].payload_valid;
    assign m_tlast  = q_reg[0].frame_last;

    assign b       = s_tdata;
    assign restart = s_tuser[0];

    // Effective state for this byte: stream_start clears it first
    always_comb begin
        if (restart) begin
            cur_mode   = mjsd_pkg::MODE_MAIN;
            cur_line   = '0;
            cur_tag    = '0;
            cur_bnd    = '0;
            cur_lastc  = '0;
            cur_phase  = mjsd_pkg::PH_BLANK;
            cur_accum  = '0;
            cur_flen   = '0;
            cur_off    = '0;
            cur_seen   = 1'b0;
            cur_lead   = mjsd_pkg::LEAD_NONE;
            cur_held   = '0;
            cur_single = 1'b0;
        end else begin
            cur_mode   = mode_reg;
            cur_line   = line_reg;
            cur_tag    = tag_reg;
            cur_bnd    = bnd_reg;
            cur_lastc  = lastc_reg;
            cur_phase  = phase_reg;
            cur_accum  = accum_reg;
            cur_flen   = flen_reg;
            cur_off    = off_reg;
            cur_seen   = seen_reg;
            cur_lead   = lead_reg;
            cur_held   = held_reg;
            cur_single = single_reg;
        end
    end

    // Decimal accumulate with saturation
    assign is_digit  = (b >= mjsd_pkg::CHAR_ZERO) && (b <= mjsd_pkg::CHAR_NINE);
    assign is_blank  = (b inside {mjsd_pkg::CHAR_SPACE, [mjsd_pkg::CHAR_TAB:mjsd_pkg::CHAR_CR]});
    assign accum_mul = {cur_accum, 3'b000} + {2'b00, cur_accum, 1'b0}
                     + {{LENGTH_BITS{1'b0}}, b[3:0]};
    assign accum_sat = (accum_mul > {4'b0000, LEN_MAX}) ? LEN_MAX
                                                        : accum_mul[LENGTH_BITS-1:0];

    // Frame byte counting
    assign off_inc    = cur_off + LENGTH_BITS'(1);
    assign frame_done = (off_inc >= cur_flen);

    assign new_flen = (cur_tag == 4'(mjsd_pkg::TAG_LEN)) ? cur_accum : cur_flen;

    // Per-byte parse
    always_comb begin
        mode_next   = mode_reg;
        line_next   = line_reg;
        tag_next    = tag_reg;
        bnd_next    = bnd_reg;
        lastc_next  = lastc_reg;
        phase_next  = phase_reg;
        accum_next  = accum_reg;
        flen_next   = flen_reg;
        off_next    = off_reg;
        seen_next   = seen_reg;
        lead_next   = lead_reg;
        held_next   = held_reg;
        single_next = single_reg;
        push0       = 1'b0;
        push1       = 1'b0;
        res0        = '0;
        res1        = '0;
        set_seen    = 1'b1;

        if (accept) begin
            mode_next   = cur_mode;
            line_next   = cur_line;
            tag_next    = cur_tag;
            bnd_next    = cur_bnd;
            lastc_next  = cur_lastc;
            phase_next  = cur_phase;
            accum_next  = cur_accum;
            flen_next   = cur_flen;
            off_next    = cur_off;
            seen_next   = cur_seen;
            lead_next   = cur_lead;
            held_next   = cur_held;
            single_next = cur_single;

            if (cur_single) begin
                push0 = 1'b1;
                res0  = '{payload_byte: b, payload_valid: 1'b1, frame_last: s_tlast};
            end else if (cur_lead == mjsd_pkg::LEAD_NONE) begin
                if (s_tlast) begin
                    single_next = 1'b1;
                    push0 = 1'b1;
                    res0  = '{payload_byte: b, payload_valid: 1'b1, frame_last: 1'b1};
                end else begin
                    held_next = b;
                    lead_next = mjsd_pkg::LEAD_ONE;
                end
            end else if (cur_lead == mjsd_pkg::LEAD_ONE) begin
                lead_next = mjsd_pkg::LEAD_DONE;
                if (cur_held == mjsd_pkg::CHAR_DASH && b == mjsd_pkg::CHAR_DASH) begin
                    // Parser is still clear here: "--" leaves a two-char boundary prefix
                    line_next  = LL_W'(2);
                    bnd_next   = mjsd_pkg::BOUNDARY_LEN;
                    lastc_next = mjsd_pkg::CHAR_DASH;
                end else begin
                    single_next = 1'b1;
                    push0 = 1'b1;
                    push1 = 1'b1;
                    res0  = '{payload_byte: cur_held, payload_valid: 1'b1, frame_last: 1'b0};
                    res1  = '{payload_byte: b, payload_valid: 1'b1, frame_last: s_tlast};
                end
            end else if (cur_mode == mjsd_pkg::MODE_FRAME) begin
                off_next = off_inc;
                push0 = 1'b1;
                res0  = '{payload_byte: b, payload_valid: 1'b1,
                          frame_last: frame_done || s_tlast};
                if (frame_done) begin
                    mode_next  = mjsd_pkg::MODE_PART;
                    line_next  = '0;
                    tag_next   = '0;
                    bnd_next   = '0;
                    lastc_next = '0;
                    phase_next = mjsd_pkg::PH_BLANK;
                    accum_next = '0;
                    off_next   = '0;
                    seen_next  = 1'b0;
                end
            end else if (b != 8'h00) begin
                if (b == mjsd_pkg::CHAR_LF && cur_line != '0 &&
                    cur_lastc == mjsd_pkg::CHAR_CR) begin
                    // End of a header line
                    flen_next = new_flen;
                    if (cur_bnd == mjsd_pkg::BOUNDARY_LEN) begin
                        mode_next = mjsd_pkg::MODE_PART;
                    end else if (cur_line == LL_W'(1) && cur_seen &&
                                 cur_mode == mjsd_pkg::MODE_PART) begin
                        if (new_flen == '0) begin
                            // Empty frame: report its end only
                            push0    = 1'b1;
                            res0     = '{payload_byte: 8'h00, payload_valid: 1'b0,
                                         frame_last: 1'b1};
                            set_seen = 1'b0;
                            seen_next = 1'b0;
                        end else begin
                            mode_next = mjsd_pkg::MODE_FRAME;
                            off_next  = '0;
                        end
                    end
                    line_next  = '0;
                    tag_next   = '0;
                    bnd_next   = '0;
                    lastc_next = '0;
                    phase_next = mjsd_pkg::PH_BLANK;
                    accum_next = '0;
                    if (set_seen) begin
                        seen_next = 1'b1;
                    end
                end else if (cur_line < LINE_CAP_W) begin
                    // Store one line character
                    if (cur_line < LL_W'(mjsd_pkg::TAG_LEN) &&
                        LL_W'(cur_tag) == cur_line &&
                        mjsd_pkg::LEN_TAG[cur_line[3:0]] == b) begin
                        tag_next = cur_tag + 4'd1;
                    end
                    if (cur_line < LL_W'(2) && LL_W'(cur_bnd) == cur_line &&
                        b == mjsd_pkg::CHAR_DASH) begin
                        bnd_next = cur_bnd + 2'd1;
                    end
                    if (cur_line >= LL_W'(mjsd_pkg::VALUE_POS)) begin
                        case (cur_phase)
                            mjsd_pkg::PH_BLANK: begin
                                if (!is_blank) begin
                                    if (b == mjsd_pkg::CHAR_PLUS) begin
                                        phase_next = mjsd_pkg::PH_DIGIT;
                                    end else if (is_digit) begin
                                        accum_next = LENGTH_BITS'(b[3:0]);
                                        phase_next = mjsd_pkg::PH_DIGIT;
                                    end else begin
                                        accum_next = '0;
                                        phase_next = mjsd_pkg::PH_DONE;
                                    end
                                end
                            end
                            mjsd_pkg::PH_DIGIT: begin
                                if (is_digit) begin
                                    accum_next = accum_sat;
                                end else begin
                                    phase_next = mjsd_pkg::PH_DONE;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    lastc_next = b;
                    line_next  = cur_line + LL_W'(1);
                end
            end

            // Stream end returns the parser state to its reset values
            if (s_tlast) begin
                mode_next   = mjsd_pkg::MODE_MAIN;
                line_next   = '0;
                tag_next    = '0;
                bnd_next    = '0;
                lastc_next  = '0;
                phase_next  = mjsd_pkg::PH_BLANK;
                accum_next  = '0;
                flen_next   = '0;
                off_next    = '0;
                seen_next   = 1'b0;
                lead_next   = mjsd_pkg::LEAD_NONE;
                held_next   = '0;
                single_next = 1'b0;
            end
        end
    end

    // Output queue: pop from the head, append up to two results
    always_comb begin
        for (int i = 0; i < QD; i++) begin
            q_next[i] = q_reg[i];
        end
        cnt_pop = cnt_reg;
        if (pop) begin
            for (int i = 0; i < QD - 1; i++) begin
                q_next[i] = q_reg[i+1];
            end
            cnt_pop = cnt_reg - 2'd1;
        end
        for (int i = 0; i < QD; i++) begin
            if (push0 && cnt_pop == 2'(i)) begin
                q_next[i] = res0;
            end
            if (push1 && (cnt_pop + 2'd1) == 2'(i)) begin
                q_next[i] = res1;
            end
        end
        cnt_next = cnt_pop + {1'b0, push0} + {1'b0, push1};
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QD; i++) begin
            q_reg[i] <= q_next[i];
        end
        if (!aresetn) begin
            cnt_reg    <= '0;
            mode_reg   <= mjsd_pkg::MODE_MAIN;
            line_reg   <= '0;
            tag_reg    <= '0;
            bnd_reg    <= '0;
            lastc_reg  <= '0;
            phase_reg  <= mjsd_pkg::PH_BLANK;
            accum_reg  <= '0;
            flen_reg   <= '0;
            off_reg    <= '0;
            seen_reg   <= 1'b0;
            lead_reg   <= mjsd_pkg::LEAD_NONE;
            held_reg   <= '0;
            single_reg <= 1'b0;
        end else begin
            cnt_reg    <= cnt_next;
            mode_reg   <= mode_next;
            line_reg   <= line_next;
            tag_reg    <= tag_next;
            bnd_reg    <= bnd_next;
            lastc_reg  <= lastc_next;
            phase_reg  <= phase_next;
            accum_reg  <= accum_next;
            flen_reg   <= flen_next;
            off_reg    <= off_next;
            seen_reg   <= seen_next;
            lead_reg   <= lead_next;
            held_reg   <= held_next;
            single_reg <= single_next;
        end
    end

endmodule

// ===== sim/multipart_jpeg_stream_deframer_test.sv =====
`timescale 1ns / 1ps

module multipart_jpeg_stream_deframer_test;

    localparam int unsigned LINE_CAP    = 1000;
    localparam int unsigned LENGTH_BITS = 24;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_VT  = 8'h0B;
    localparam logic [7:0] CHAR_FF  = 8'h0C;

    typedef struct packed {
        logic [7:0] value;
        logic       start;
        logic       eos;
    } body_byte_t;

    // Deframer model plus the queue of payload transactions it predicts
    class deframer_scoreboard;
        mjsd_pkg::mode_t        mode;
        int unsigned            line_len;
        int unsigned            tag_len;
        logic [1:0]             dash_len;
        logic [7:0]             last_ch;
        mjsd_pkg::phase_t       phase;
        logic [LENGTH_BITS-1:0] num_acc;
        logic [LENGTH_BITS-1:0] frame_len;
        logic [LENGTH_BITS-1:0] frame_off;
        bit                     hdr_seen;
        mjsd_pkg::lead_t        lead;
        logic [7:0]             held;
        bit                     single;
        mjsd_pkg::result_t      payload_q[$];
        int                     errors;

        function new();
            errors = 0;
            reset_state();
        endfunction

        function void clear_line();
            line_len = 0;
            tag_len  = 0;
            dash_len = 0;
            last_ch  = 8'h00;
            phase    = mjsd_pkg::PH_BLANK;
            num_acc  = '0;
        endfunction

        function void reset_state();
            mode = mjsd_pkg::MODE_MAIN;
            clear_line();
            frame_len = '0;
            frame_off = '0;
            hdr_seen  = 1'b0;
            lead      = mjsd_pkg::LEAD_NONE;
            held      = 8'h00;
            single    = 1'b0;
        endfunction

        function void push_payload(logic [7:0] b, bit v, bit l);
            mjsd_pkg::result_t r;
            r.payload_byte  = v ? b : 8'h00;
            r.payload_valid = v;
            r.frame_last    = l;
            payload_q.push_back(r);
        endfunction

        // atoi-style scan of the Content-Length value, saturating
        function void scan_length_char(logic [7:0] c);
            bit              digit;
            longint unsigned v;
            digit = (c >= mjsd_pkg::CHAR_ZERO) && (c <= mjsd_pkg::CHAR_NINE);
            case (phase)
                mjsd_pkg::PH_BLANK: begin
                    if (c == mjsd_pkg::CHAR_SPACE ||
                        (c >= mjsd_pkg::CHAR_TAB && c <= mjsd_pkg::CHAR_CR)) begin
                        return;
                    end
                    if (c == mjsd_pkg::CHAR_PLUS) begin
                        phase = mjsd_pkg::PH_DIGIT;
                    end else if (digit) begin
                        num_acc = LENGTH_BITS'(c - mjsd_pkg::CHAR_ZERO);
                        phase   = mjsd_pkg::PH_DIGIT;
                    end else begin
                        num_acc = '0;
                        phase   = mjsd_pkg::PH_DONE;
                    end
                end
                mjsd_pkg::PH_DIGIT: begin
                    if (digit) begin
                        v = 64'(num_acc) * 64'd10 + 64'(c - mjsd_pkg::CHAR_ZERO);
                        num_acc = (v > 64'(LEN_MAX)) ? LEN_MAX : v[LENGTH_BITS-1:0];
                    end else begin
                        phase = mjsd_pkg::PH_DONE;
                    end
                end
                default: ;
            endcase
        endfunction

        function void parse_header_char(logic [7:0] c);
            int unsigned p;
            bit          set_seen;
            p = line_len;
            if (c == CHAR_NUL) begin
                return;
            end
            // CR LF closes the line
            if (c == mjsd_pkg::CHAR_LF && p > 0 && last_ch == mjsd_pkg::CHAR_CR) begin
                set_seen = 1'b1;
                if (tag_len == mjsd_pkg::TAG_LEN) begin
                    frame_len = num_acc;
                end
                if (dash_len == mjsd_pkg::BOUNDARY_LEN) begin
                    mode = mjsd_pkg::MODE_PART;
                end else if (p == 1 && hdr_seen && mode == mjsd_pkg::MODE_PART) begin
                    if (frame_len == 0) begin
                        push_payload(8'h00, 1'b0, 1'b1);
                        set_seen = 1'b0;
                        hdr_seen = 1'b0;
                    end else begin
                        mode      = mjsd_pkg::MODE_FRAME;
                        frame_off = '0;
                    end
                end
                clear_line();
                if (set_seen) begin
                    hdr_seen = 1'b1;
                end
                return;
            end
            // store the character unless the line is at its cap
            if (p < LINE_CAP) begin
                if (p < mjsd_pkg::TAG_LEN && tag_len == p && mjsd_pkg::LEN_TAG[p] == c) begin
                    tag_len = p + 1;
                end
                if (p < 2 && dash_len == p && c == mjsd_pkg::CHAR_DASH) begin
                    dash_len = dash_len + 1'b1;
                end
                if (p >= mjsd_pkg::VALUE_POS) begin
                    scan_length_char(c);
                end
                last_ch  = c;
                line_len = p + 1;
            end
        endfunction

        // Accepted input transaction: predict its payload transactions
        function void note_byte(logic [7:0] b, bit st, bit eos);
            bit last;
            if (st) begin
                reset_state();
            end
            if (single) begin
                push_payload(b, 1'b1, eos);
            end else if (lead == mjsd_pkg::LEAD_NONE) begin
                if (eos) begin
                    single = 1'b1;
                    push_payload(b, 1'b1, 1'b1);
                end else begin
                    held = b;
                    lead = mjsd_pkg::LEAD_ONE;
                end
            end else if (lead == mjsd_pkg::LEAD_ONE) begin
                lead = mjsd_pkg::LEAD_DONE;
                if (held == mjsd_pkg::CHAR_DASH && b == mjsd_pkg::CHAR_DASH) begin
                    parse_header_char(held);
                    parse_header_char(b);
                end else begin
                    single = 1'b1;
                    push_payload(held, 1'b1, 1'b0);
                    push_payload(b, 1'b1, eos);
                end
            end else if (mode == mjsd_pkg::MODE_FRAME) begin
                frame_off = frame_off + 1'b1;
                last = (frame_off >= frame_len);
                push_payload(b, 1'b1, last | eos);
                if (last) begin
                    mode = mjsd_pkg::MODE_PART;
                    clear_line();
                    frame_off = '0;
                    hdr_seen  = 1'b0;
                end
            end else begin
                parse_header_char(b);
            end
            if (eos) begin
                reset_state();
            end
        endfunction

        // Accepted output transaction: compare with the oldest prediction
        function void check_payload(mjsd_pkg::result_t got);
            mjsd_pkg::result_t want;
            if (payload_q.size() == 0) begin
                $display("%0t: unexpected payload transaction byte %h valid %b last %b",
                         $time, got.payload_byte, got.payload_valid, got.frame_last);
                errors++;
                return;
            end
            want = payload_q.pop_front();
            if (got.payload_byte !== want.payload_byte) begin
                $display("%0t: payload_byte expected %h actual %h",
                         $time, want.payload_byte, got.payload_byte);
                errors++;
            end
            if (got.payload_valid !== want.payload_valid) begin
                $display("%0t: payload_valid expected %b actual %b",
                         $time, want.payload_valid, got.payload_valid);
                errors++;
            end
            if (got.frame_last !== want.frame_last) begin
                $display("%0t: frame_last expected %b actual %b",
                         $time, want.frame_last, got.frame_last);
                errors++;
            end
        endfunction

        function int pending();
            return payload_q.size();
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] byte_value
    logic [0:0] s_tuser;   // [0] stream_start
    logic       s_tlast;   // stream_end
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] payload_byte
    logic [0:0] m_tuser;   // [0] payload_valid
    logic       m_tlast;   // frame_last

    deframer_scoreboard board;
    body_byte_t         body_q[$];
    int unsigned        send_idle_pct;
    int unsigned        recv_idle_pct;
    int unsigned        stall_left;

    multipart_jpeg_stream_deframer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Receiver: random back-pressure, or a long hold-off when requested
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watch both channels; input first so its results are queued before any check
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                board.note_byte(s_tdata, s_tuser[0], s_tlast);
            end
            if (m_tvalid && m_tready) begin
                board.check_payload(mjsd_pkg::result_t'({m_tdata, m_tuser[0], m_tlast}));
            end
        end
    end

    // ---- body construction ----

    function automatic void put_byte(logic [7:0] value, bit start = 1'b0, bit eos = 1'b0);
        body_byte_t t;
        t.value = value;
        t.start = start;
        t.eos   = eos;
        body_q.push_back(t);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            put_byte(s[i]);
        end
    endfunction

    function automatic void put_crlf();
        put_byte(mjsd_pkg::CHAR_CR);
        put_byte(mjsd_pkg::CHAR_LF);
    endfunction

    function automatic void close_stream();
        body_byte_t t;
        t = body_q[$];
        t.eos = 1'b1;
        body_q[$] = t;
    endfunction

    function automatic void put_boundary_line();
        put_text("--");
        repeat ($urandom_range(0, 8)) put_byte(8'($urandom_range(8'h61, 8'h7A)));
        put_crlf();
    endfunction

    // Filler header line; no CR inside, may hold NUL, lone LF and high bytes
    function automatic void put_junk_line();
        logic [7:0] ch;
        put_text("X-");
        repeat ($urandom_range(1, 16)) begin
            case ($urandom_range(19))
                0: ch = CHAR_NUL;
                1: ch = mjsd_pkg::CHAR_LF;
                2: ch = 8'($urandom_range(8'h80, 8'hFF));
                default: ch = 8'($urandom_range(8'h20, 8'h7E));
            endcase
            put_byte(ch);
        end
        put_crlf();
    endfunction

    // Content-Length line in several spellings; cur_len tracks the parsed value
    function automatic void put_length_line(inout int unsigned cur_len);
        int unsigned form;
        int unsigned v;
        logic [7:0]  ch;
        logic [7:0]  prev;
        form = $urandom_range(99);
        if (form < 5) begin
            // tag in the wrong case is not recognized
            put_text("Content-length: 9");
            put_crlf();
            return;
        end
        put_text("Content-Length:");
        // character right after the colon is never scanned
        case ($urandom_range(5))
            0: ch = "9";
            1: ch = mjsd_pkg::CHAR_TAB;
            2: ch = "x";
            default: ch = mjsd_pkg::CHAR_SPACE;
        endcase
        put_byte(ch);
        prev = ch;
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(5))
                    0: ch = mjsd_pkg::CHAR_TAB;
                    1: ch = CHAR_VT;
                    2: ch = CHAR_FF;
                    3: ch = mjsd_pkg::CHAR_LF;
                    4: ch = mjsd_pkg::CHAR_CR;
                    default: ch = mjsd_pkg::CHAR_SPACE;
                endcase
                if (prev == mjsd_pkg::CHAR_CR && ch == mjsd_pkg::CHAR_LF) begin
                    ch = mjsd_pkg::CHAR_SPACE;
                end
                put_byte(ch);
                prev = ch;
            end
        end
        if (form < 10) begin
            put_text("-7");
            cur_len = 0;
        end else if (form < 14) begin
            put_text("abc");
            cur_len = 0;
        end else if (form < 18) begin
            put_text("123456789012");
            cur_len = 32'(LEN_MAX);
        end else begin
            v = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24);
            if ($urandom_range(4) == 0) begin
                put_byte(mjsd_pkg::CHAR_PLUS);
            end
            if ($urandom_range(5) == 0) begin
                put_text("00");
            end
            put_text($sformatf("%0d", v));
            cur_len = v;
        end
        if ($urandom_range(4) == 0) begin
            put_text(" ;q");
        end
        put_crlf();
    endfunction

    // Well-formed multipart body with random content, sometimes cut short
    function automatic void put_multipart();
        int unsigned nparts;
        int unsigned cur_len;
        nparts  = $urandom_range(1, 3);
        cur_len = 0;
        put_boundary_line();
        for (int np = 0; np < nparts; np++) begin
            if (np > 0) begin
                if ($urandom_range(3) != 0) begin
                    put_crlf();
                end
                put_boundary_line();
            end
            repeat ($urandom_range(0, 2)) begin
                if ($urandom_range(1) == 0) begin
                    put_text("Content-Type: image/jpeg");
                    put_crlf();
                end else begin
                    put_junk_line();
                end
            end
            if ($urandom_range(4) != 0) begin
                put_length_line(cur_len);
            end
            put_crlf();
            // saturated length: end the stream inside the frame
            if (cur_len > 64) begin
                repeat ($urandom_range(1, 5)) put_byte(8'($urandom_range(255)));
                return;
            end
            if (cur_len != 0) begin
                if ($urandom_range(11) == 0) begin
                    repeat ($urandom_range(1, cur_len)) put_byte(8'($urandom_range(255)));
                    return;
                end
                repeat (cur_len) put_byte(8'($urandom_range(255)));
            end
        end
        if ($urandom_range(2) == 0) begin
            put_crlf();
        end
    endfunction

    function automatic void put_stream();
        int unsigned first;
        int unsigned kind;
        logic [7:0]  b0;
        logic [7:0]  b1;
        body_byte_t  t;
        first = body_q.size();
        kind  = $urandom_range(99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 10)) put_byte(8'($urandom_range(255)));
        end else if (kind < 20) begin
            // plain image: first two bytes are not both dashes
            b0 = ($urandom_range(1) == 0) ? mjsd_pkg::CHAR_DASH : 8'($urandom_range(255));
            b1 = 8'($urandom_range(255));
            if (b0 == mjsd_pkg::CHAR_DASH && b1 == mjsd_pkg::CHAR_DASH) begin
                b1 = 8'h2E;
            end
            put_byte(b0);
            put_byte(b1);
            repeat ($urandom_range(0, 20)) put_byte(8'($urandom_range(255)));
        end else begin
            put_multipart();
        end
        t = body_q[first];
        t.start = 1'($urandom_range(1));
        body_q[first] = t;
        // occasional damage: a corrupted byte or a restart mid-stream
        if ($urandom_range(15) == 0) begin
            kind = $urandom_range(first, body_q.size() - 1);
            t = body_q[kind];
            t.value = 8'($urandom_range(255));
            body_q[kind] = t;
        end
        if ($urandom_range(19) == 0) begin
            kind = $urandom_range(first, body_q.size() - 1);
            t = body_q[kind];
            t.start = 1'b1;
            body_q[kind] = t;
        end
        close_stream();
    endfunction

    function automatic void put_directed();
        // one-byte stream
        put_byte(8'hFF, 1'b1, 1'b1);
        // lead bytes other than two dashes pass through as one image
        put_byte(mjsd_pkg::CHAR_DASH);
        put_byte("x");
        put_byte(8'h00);
        put_byte(8'hFF, 1'b0, 1'b1);
        // boundary, then an empty line with no length: empty frame end
        put_byte(mjsd_pkg::CHAR_DASH, 1'b1);
        put_byte(mjsd_pkg::CHAR_DASH);
        put_crlf();
        put_crlf();
        close_stream();
        // restart in the middle of a stream
        put_byte(mjsd_pkg::CHAR_DASH);
        put_byte(mjsd_pkg::CHAR_DASH);
        put_byte("Z", 1'b1, 1'b1);
    endfunction

    function automatic void add_streams(int unsigned n);
        int unsigned goal;
        goal = body_q.size() + n;
        while (body_q.size() < goal) begin
            put_stream();
        end
    endfunction

    // ---- driving ----

    task automatic send_byte(body_byte_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it.value;
        s_tuser  <= it.start;
        s_tlast  <= it.eos;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_body();
        while (body_q.size() > 0) begin
            send_byte(body_q.pop_front());
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        int unsigned guard;
        guard = 0;
        while (board.pending() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        s_tuser       = 1'b0;
        s_tlast       = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_left    = 0;
        board = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // sender mostly busy, receiver mostly stalled
        send_idle_pct = 20;
        recv_idle_pct = 79;
        put_directed();
        add_streams(180);
        send_body();
        wait_drained();

        // sender mostly idle; pause halfway until every payload has come out
        send_idle_pct = 79;
        recv_idle_pct = 20;
        add_streams(90);
        send_body();
        wait_drained();
        add_streams(90);
        send_body();
        wait_drained();

        // full rate, opening with a long receiver hold-off to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_left    = 300;
        add_streams(90);
        send_body();
        add_streams(90);
        send_body();
        wait_drained();

        if (board.pending() != 0) begin
            $display("%0t: %0d expected payload transactions never arrived",
                     $time, board.pending());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
